// ===== src/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg
// shared sizes, register indexes, fit codes and sequencer states for the
// fit policy block allocator
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
	localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);
	localparam int MODE_BITS  = 2;
	localparam int ACTIVE_BITS = 5;
	localparam int CFG_DATA_BITS = 5;
	localparam int CFG_IDX_BITS  = 1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_MODE      = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_BLOCKS = 1'd1;

	localparam logic [MODE_BITS-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_BITS-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_BITS-1:0] FIT_WORST = 2'd2;

	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_ALLOCATE = 1'b1;

	localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = ACTIVE_BITS'(NUM_BLOCKS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// ===== src/fit_policy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// free capacity table with first, best and worst fit allocation
// ----------------------------------------------------------------------------
// A load request writes one table entry in the cycle it is accepted and
// leaves busy low. An allocate request raises busy and scans the first
// min(active_blocks, 16) entries one per cycle through a single compare
// unit, then subtracts the request from the chosen entry in the finish
// state; the result strobe follows in the next cycle. First fit ends the
// scan at the first fitting entry. The result is shown for one cycle only
// and is not held, and a new request may be started in that same cycle.
module fit_policy_block_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [fpba_pkg::IDX_BITS-1:0]     block_index,
	input  logic [fpba_pkg::SIZE_BITS-1:0]    size_value,
	input  logic                              last_request,
	input  logic                              cfg_we,
	input  logic [fpba_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [fpba_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output logic                              result_valid,
	output logic                              granted,
	output logic [fpba_pkg::IDX_BITS-1:0]     block_number,
	output logic [fpba_pkg::SIZE_BITS-1:0]    remaining_size,
	output logic                              last_result
);

	fpba_pkg::state_t state_q, state_d;

	logic [fpba_pkg::MODE_BITS-1:0]   fit_mode_q;
	logic [fpba_pkg::ACTIVE_BITS-1:0] active_q;

	logic [fpba_pkg::SIZE_BITS-1:0] block_free_q [fpba_pkg::NUM_BLOCKS];

	logic [fpba_pkg::SIZE_BITS-1:0] req_q;
	logic                           last_q;
	logic [fpba_pkg::MODE_BITS-1:0] mode_q;
	logic [fpba_pkg::CNT_BITS-1:0]  limit_q;
	logic [fpba_pkg::CNT_BITS-1:0]  scan_q;
	logic                           found_q;
	logic [fpba_pkg::IDX_BITS-1:0]  sel_q;
	logic [fpba_pkg::SIZE_BITS-1:0] best_q;

	logic                           result_valid_q;
	logic                           granted_q;
	logic [fpba_pkg::IDX_BITS-1:0]  block_number_q;
	logic [fpba_pkg::SIZE_BITS-1:0] remaining_q;
	logic                           last_result_q;

	logic                           accept;
	logic                           alloc_accept;
	logic                           load_accept;
	logic [fpba_pkg::CNT_BITS-1:0]  limit_d;
	logic [fpba_pkg::SIZE_BITS-1:0] cap;
	logic                           fits;
	logic                           take;
	logic                           scan_end;
	logic [fpba_pkg::SIZE_BITS-1:0] left;

	assign accept       = start && !busy;
	assign alloc_accept = accept && (operation == fpba_pkg::OP_ALLOCATE);
	assign load_accept  = accept && (operation == fpba_pkg::OP_LOAD);

	// clamp the search range to the table size
	assign limit_d = (active_q > fpba_pkg::ACTIVE_BITS'(fpba_pkg::NUM_BLOCKS)) ?
		fpba_pkg::CNT_BITS'(fpba_pkg::NUM_BLOCKS) :
		fpba_pkg::CNT_BITS'(active_q);

	// shared compare unit, one entry per cycle
	assign cap  = block_free_q[scan_q[fpba_pkg::IDX_BITS-1:0]];
	assign fits = cap >= req_q;
	always_comb begin
		take = 1'b0;
		if (fits && scan_q < limit_q) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (mode_q == fpba_pkg::FIT_BEST) begin
				take = cap < best_q;
			end else if (mode_q == fpba_pkg::FIT_WORST) begin
				take = cap > best_q;
			end
		end
	end

	assign left = best_q - req_q;

	always_comb begin
		state_d  = state_q;
		scan_end = 1'b0;
		unique case (state_q)
			fpba_pkg::ST_IDLE: begin
				if (alloc_accept) begin
					state_d = fpba_pkg::ST_SCAN;
				end
			end
			fpba_pkg::ST_SCAN: begin
				// first fit (and the unused code) stops at the first hit
				if (scan_q >= limit_q) begin
					scan_end = 1'b1;
				end else if (take && mode_q != fpba_pkg::FIT_BEST &&
						mode_q != fpba_pkg::FIT_WORST) begin
					scan_end = 1'b1;
				end
				if (scan_end) begin
					state_d = fpba_pkg::ST_FINISH;
				end
			end
			fpba_pkg::ST_FINISH: begin
				state_d = fpba_pkg::ST_IDLE;
			end
			default: begin
				state_d = fpba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= fpba_pkg::FIT_FIRST;
			active_q   <= fpba_pkg::ACTIVE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpba_pkg::CFG_FIT_MODE: begin
					fit_mode_q <= cfg_data[fpba_pkg::MODE_BITS-1:0];
				end
				fpba_pkg::CFG_ACTIVE_BLOCKS: begin
					active_q <= cfg_data[fpba_pkg::ACTIVE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fpba_pkg::NUM_BLOCKS; i++) begin
				block_free_q[i] <= '0;
			end
		end else if (load_accept) begin
			block_free_q[block_index] <= size_value;
		end else if (state_q == fpba_pkg::ST_FINISH && found_q) begin
			block_free_q[sel_q] <= left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			found_q <= 1'b0;
		end else if (alloc_accept) begin
			scan_q  <= '0;
			found_q <= 1'b0;
		end else if (state_q == fpba_pkg::ST_SCAN && !scan_end) begin
			scan_q <= scan_q + fpba_pkg::CNT_BITS'(1);
			if (take) begin
				found_q <= 1'b1;
			end
		end else if (state_q == fpba_pkg::ST_SCAN && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_accept) begin
			req_q   <= size_value;
			last_q  <= last_request;
			mode_q  <= fit_mode_q;
			limit_q <= limit_d;
		end
		if (state_q == fpba_pkg::ST_SCAN && scan_q < limit_q && take) begin
			sel_q  <= scan_q[fpba_pkg::IDX_BITS-1:0];
			best_q <= cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (state_q == fpba_pkg::ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fpba_pkg::ST_FINISH) begin
			granted_q      <= found_q;
			block_number_q <= found_q ? sel_q : '0;
			remaining_q    <= found_q ? left : '0;
			last_result_q  <= last_q;
		end
	end

	assign busy           = (state_q != fpba_pkg::ST_IDLE);
	assign result_valid   = result_valid_q;
	assign granted        = granted_q;
	assign block_number   = block_number_q;
	assign remaining_size = remaining_q;
	assign last_result    = last_result_q;

`ifndef SYNTH
	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpba_pkg::ST_FINISH) |=> result_valid)
		else $error("finish cycle without result strobe");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == fpba_pkg::ST_FINISH))
		else $error("result strobe without finish cycle");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && granted) |->
			(fpba_pkg::CNT_BITS'(block_number) < limit_q))
		else $error("granted block outside the searched range");

	a_denied_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !granted) |-> (block_number == '0 && remaining_size == '0))
		else $error("denied request carries nonzero fields");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpba_pkg::ST_SCAN) |->
			(scan_q <= fpba_pkg::CNT_BITS'(fpba_pkg::NUM_BLOCKS)))
		else $error("scan index past the table");
`endif

endmodule
